@@ rtl/longest_window_with_target_sum_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef LONGEST_WINDOW_WITH_TARGET_SUM_ASSERT_SVH
`define LONGEST_WINDOW_WITH_TARGET_SUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lwts_pkg.sv @@
`default_nettype none

package lwts_pkg;

  // Port widths of the request and result fields.
  localparam int VALUE_W  = 16;
  localparam int TARGET_W = 26;
  localparam int BEST_W   = 11;

endpackage

`default_nettype wire

@@ rtl/lwts_ram.sv @@
`default_nettype none

module lwts_ram #(
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/longest_window_with_target_sum.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   in_value, in_last_element
// out       output     out_valid / out_stall out_best_length, out_overflow, out_final_res
// cfg       input      cfg_valid / cfg_ready cfg_target_sum
//
// An item is taken in ST_IDLE, then ST_EVAL pops values from the window and finishes it;
// each pop is one read of the window memory followed by one subtract, so the loop over
// the memory read port sets the rate. Each value is popped at most once per array.
// Reset (rst_n low, synchronous) clears the window, counts, best length and target.
// A result waits in the output register while out_stall is high; the next request is
// still taken, and the block holds its finished result until the output register frees.
`default_nettype none

module longest_window_with_target_sum
  import lwts_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire logic                in_last_element,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [BEST_W-1:0]   out_best_length,
  output logic                     out_overflow,
  output logic                     out_final_res,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [TARGET_W-1:0] cfg_target_sum
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = VALUE_BITS + CNT_W;
  localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  localparam logic [AW:0]      MAX_IDX  = (AW + 1)'(MAX_LEN);
  localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_LEN - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LEN);

  logic                  state_r, state_nxt;
  logic [AW-1:0]         oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      elem_r, elem_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      best_r, best_nxt;
  logic [TARGET_W-1:0]   target_r, target_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BEST_W-1:0]     out_best_r, out_best_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_final_r, out_final_nxt;

  logic                  in_accept;
  logic                  item_ovf;
  logic [VALUE_BITS-1:0] value_in;
  logic [AW:0]           slot_sum;
  logic [AW-1:0]         slot;
  logic [AW-1:0]         oldest_inc;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_val;
  logic [CMP_W-1:0]      sum_ext;
  logic [CMP_W-1:0]      tgt_ext;
  logic                  need_pop;
  logic                  out_free;
  logic                  wr_en;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign value_in = VALUE_BITS'(in_value);
  assign item_ovf = (elem_r >= MAX_CNT);

  // The new value lands just past the newest entry, wrapping around the ring.
  assign slot_sum   = {1'b0, oldest_r} + (AW + 1)'(count_r);
  assign slot       = (slot_sum >= MAX_IDX) ? AW'(slot_sum - MAX_IDX) : AW'(slot_sum);
  assign oldest_inc = (oldest_r == LAST_IDX) ? '0 : oldest_r + 1'b1;

  assign sum_ext  = CMP_W'(sum_r);
  assign tgt_ext  = CMP_W'(target_r);
  assign need_pop = !ovf_r && (sum_ext > tgt_ext) && (count_r != '0);
  assign out_free = !out_valid_r || !out_stall;

  assign wr_en = in_accept && !item_ovf;

  // While popping, fetch the entry after the one being removed so that it is ready
  // when the next compare asks for it.
  assign rd_addr = ((state_r == ST_EVAL) && need_pop) ? oldest_inc : oldest_r;

  lwts_ram #(
    .AW (AW),
    .DW (VALUE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (value_in),
    .rd_addr (rd_addr),
    .rd_data (rd_val)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    elem_nxt      = elem_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    target_nxt    = target_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_best_nxt  = out_best_r;
    out_ovf_nxt   = out_ovf_r;
    out_final_nxt = out_final_r;

    if (cfg_valid && cfg_ready) begin
      target_nxt = cfg_target_sum;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          ovf_nxt   = item_ovf;
          last_nxt  = in_last_element;
          state_nxt = ST_EVAL;
          if (!item_ovf) begin
            count_nxt = count_r + 1'b1;
            elem_nxt  = elem_r + 1'b1;
            sum_nxt   = sum_r + SUM_W'(value_in);
          end
        end
      end
      ST_EVAL: begin
        if (need_pop) begin
          sum_nxt    = sum_r - SUM_W'(rd_val);
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
        end else if (out_free) begin
          if (!ovf_r && (sum_ext == tgt_ext) && (count_r > best_r)) begin
            best_nxt = count_r;
          end
          out_valid_nxt = 1'b1;
          out_best_nxt  = BEST_W'(best_nxt);
          out_ovf_nxt   = ovf_r;
          out_final_nxt = last_r;
          state_nxt     = ST_IDLE;
          if (last_r) begin
            oldest_nxt = '0;
            count_nxt  = '0;
            elem_nxt   = '0;
            sum_nxt    = '0;
            best_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      elem_r      <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      elem_r      <= elem_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      target_r    <= target_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r       <= ovf_nxt;
    last_r      <= last_nxt;
    out_best_r  <= out_best_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_best_length = out_best_r;
  assign out_overflow    = out_ovf_r;
  assign out_final_res   = out_final_r;

endmodule

`default_nettype wire

@@ rtl/lwts_checker.sv @@
`default_nettype none

`include "longest_window_with_target_sum_assert.svh"

module lwts_checker
  import lwts_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [BEST_W-1:0] out_best_length,
  input wire logic              out_overflow,
  input wire logic              out_final_res
);

  // A stalled result stays in place with the same contents.
  `LWTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_best_length) && $stable(out_overflow) && $stable(out_final_res),
    "stalled result changed or dropped")

  // Only one request is in flight: the cycle after a request is taken, input is stalled.
  `LWTS_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall,
    "input taken again before the previous request finished")

  // Finishing a request always leaves its result in the output register.
  `LWTS_ASSERT_NOW(a_done_has_result, $fell(in_stall), out_valid,
    "request finished without a result")

  // A window can never be longer than the array limit.
  `LWTS_ASSERT_NOW(a_best_bound, out_valid,
    (MAX_LEN >= (2 ** BEST_W)) || (int'(out_best_length) <= MAX_LEN),
    "best length beyond array limit")

endmodule

bind longest_window_with_target_sum lwts_checker #(.MAX_LEN(MAX_LEN)) u_lwts_checker (.*);

`default_nettype wire

@@ dv/longest_window_with_target_sum_tb.sv @@
`default_nettype none

module longest_window_with_target_sum_tb
  import lwts_pkg::*;
();

  localparam int WINDOW_DEPTH   = 1024;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SET_ITEMS      = 60;
  localparam int DIRECTED_ROWS  = 21;

  localparam logic [TARGET_W-1:0] TARGET_MAX      = '1;
  localparam logic [TARGET_W-1:0] FULL_WINDOW_SUM = WINDOW_DEPTH * 65535;

  typedef struct packed {
    logic [BEST_W-1:0] best_length;
    logic              overflow;
    logic              final_res;
  } window_result_t;

  typedef enum logic {ROW_VALUE, ROW_TARGET} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [TARGET_W-1:0] data;
    logic                last;
    logic                typed;
    window_result_t      want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                in_last_element = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BEST_W-1:0]   out_best_length;
  logic                out_overflow;
  logic                out_final_res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TARGET_W-1:0] cfg_target_sum = '0;

  // Model of the window: circular store, running sum and best length per array.
  logic [VALUE_W-1:0]  win_mem [WINDOW_DEPTH];
  logic [9:0]          win_head;
  logic [10:0]         win_len;
  logic [10:0]         elem_cnt;
  logic [26:0]         win_sum;
  logic [BEST_W-1:0]   best_len;
  logic [TARGET_W-1:0] target_cfg;

  window_result_t awaited_results [$];
  stim_row_t      directed_rows [DIRECTED_ROWS];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off_req = 1'b0;
  int  mismatch_count = 0;
  int  quiet_cycles = 0;

  longest_window_with_target_sum #(
    .MAX_LEN    (WINDOW_DEPTH),
    .VALUE_BITS (VALUE_W)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_length (out_best_length),
    .out_overflow    (out_overflow),
    .out_final_res   (out_final_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_target_sum  (cfg_target_sum)
  );

  always #6 clk = ~clk;

  function automatic void clear_window();
    win_head = '0;
    win_len  = '0;
    elem_cnt = '0;
    win_sum  = '0;
    best_len = '0;
  endfunction

  function automatic window_result_t next_window_result(input logic [VALUE_W-1:0] v,
                                                        input logic last);
    window_result_t r;
    logic [9:0]     slot;
    r.overflow = 1'b0;
    if (elem_cnt >= WINDOW_DEPTH) begin
      r.overflow = 1'b1;
    end else begin
      slot = win_head + win_len[9:0];
      win_mem[slot] = v;
      win_len  = win_len + 1'b1;
      elem_cnt = elem_cnt + 1'b1;
      win_sum  = win_sum + v;
      while (win_sum > target_cfg && win_len != 0) begin
        win_sum  = win_sum - win_mem[win_head];
        win_head = win_head + 1'b1;
        win_len  = win_len - 1'b1;
      end
      if (win_sum == target_cfg && win_len > best_len) begin
        best_len = win_len;
      end
    end
    r.best_length = best_len;
    r.final_res   = last;
    if (last) begin
      clear_window();
    end
    return r;
  endfunction

  // Values are drawn relative to the target so that windows often hit it exactly.
  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    int vmax;
    roll = $urandom_range(0, 99);
    vmax = int'(target_cfg) / int'($urandom_range(1, 6));
    if (vmax > 65535) vmax = 65535;
    if (vmax < 1) vmax = 1;
    if (roll < 12) return '0;
    if (roll < 20) return VALUE_W'($urandom);
    if (roll < 23) return '1;
    return VALUE_W'($urandom_range(0, vmax));
  endfunction

  function automatic logic [TARGET_W-1:0] pick_target(input int set_idx, input int phase);
    case (set_idx)
      0: return TARGET_W'($urandom_range(1, 60));
      1: return TARGET_W'($urandom_range(61, 300000));
      2: return (phase == 1) ? TARGET_MAX : '0;
      default: return TARGET_W'($urandom);
    endcase
  endfunction

  task automatic offer_value(input logic [VALUE_W-1:0] v, input logic last,
                             input logic typed, input window_result_t want);
    window_result_t predicted;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_value        <= v;
    in_last_element <= last;
    do @(posedge clk); while (in_stall);
    predicted = next_window_result(v, last);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Lower the request and let every result come back before anything else happens.
  task automatic drain_results(input int settle_cycles);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] t);
    drain_results(4);
    cfg_valid      <= 1'b1;
    cfg_target_sum <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    target_cfg = t;
  endtask

  task automatic send_arrays(input int item_goal);
    int sent;
    int len;
    bit noisy;
    logic [VALUE_W-1:0] v;
    sent = 0;
    while (sent < item_goal) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      noisy = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        v = noisy ? VALUE_W'($urandom) : pick_value();
        offer_value(v, i == len - 1, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // Fills one array to the limit with full-scale values, then runs past the limit.
  task automatic send_overflow_array();
    int len;
    logic [VALUE_W-1:0] v;
    len = WINDOW_DEPTH + $urandom_range(2, 6);
    for (int i = 0; i < len; i++) begin
      v = (i < WINDOW_DEPTH) ? '1 : VALUE_W'($urandom);
      offer_value(v, i == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    window_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, actual best_length %0d overflow %0d final %0d",
                 $time, out_best_length, out_overflow, out_final_res);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_best_length !== want.best_length) begin
          $display("%0t: best_length expected %0d, actual %0d",
                   $time, want.best_length, out_best_length);
          mismatch_count++;
        end
        if (out_overflow !== want.overflow) begin
          $display("%0t: overflow expected %0d, actual %0d", $time, want.overflow, out_overflow);
          mismatch_count++;
        end
        if (out_final_res !== want.final_res) begin
          $display("%0t: final_res expected %0d, actual %0d",
                   $time, want.final_res, out_final_res);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      // Zero target after reset: runs of zeros match, a nonzero value empties the window.
      '{ROW_VALUE,  26'd0,     1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}},
      '{ROW_VALUE,  26'd0,     1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
      '{ROW_VALUE,  26'd5,     1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
      '{ROW_VALUE,  26'd0,     1'b1, 1'b1, '{11'd2, 1'b0, 1'b1}},
      '{ROW_TARGET, 26'd10,    1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'd65535, 1'b0, 1'b1, '{11'd0, 1'b0, 1'b0}},
      '{ROW_VALUE,  26'd3,     1'b0, 1'b1, '{11'd0, 1'b0, 1'b0}},
      '{ROW_VALUE,  26'd7,     1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}},
      '{ROW_VALUE,  26'd0,     1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'd1,     1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'd2,     1'b1, 1'b0, '0},
      '{ROW_TARGET, TARGET_MAX, 1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'd65535, 1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'd65535, 1'b1, 1'b1, '{11'd0, 1'b0, 1'b1}},
      '{ROW_TARGET, 26'd65535, 1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'd65535, 1'b1, 1'b1, '{11'd1, 1'b0, 1'b1}},
      '{ROW_TARGET, 26'd21845, 1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'h0AAAA, 1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'h05555, 1'b0, 1'b0, '0},
      '{ROW_VALUE,  26'h00000, 1'b1, 1'b0, '0},
      '{ROW_VALUE,  26'h05555, 1'b1, 1'b0, '0}
    };
    clear_window();
    target_cfg = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    stall_pct     = 81;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_TARGET) begin
        write_target(directed_rows[r].data);
      end else begin
        offer_value(directed_rows[r].data[VALUE_W-1:0], directed_rows[r].last,
                    directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 81 : 0;
      stall_pct     = (phase == 0) ? 81 : (phase == 1) ? 33 : 0;
      for (int set_idx = 0; set_idx < 4; set_idx++) begin
        write_target(pick_target(set_idx, phase));
        // With the sender never idle, a long hold-off on the result side backs up the input.
        if (phase == 2 && set_idx == 0) hold_off_req = 1'b1;
        send_arrays(SET_ITEMS);
      end
      if (phase == 2) begin
        write_target(FULL_WINDOW_SUM);
        send_overflow_array();
      end
    end

    drain_results(40);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
